@@ rtl/tnrn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_pkg: shared types and constants of the telnet receive negotiator
// Protocol codes, job descriptor passed front to back, result kinds,
// configuration record and the charset request list.
// ----------------------------------------------------------------------------
package tnrn_pkg;

  // telnet command codes
  localparam logic [7:0] T_IAC    = 8'd255;
  localparam logic [7:0] T_DONT   = 8'd254;
  localparam logic [7:0] T_DO     = 8'd253;
  localparam logic [7:0] T_WONT   = 8'd252;
  localparam logic [7:0] T_WILL   = 8'd251;
  localparam logic [7:0] T_SB     = 8'd250;
  localparam logic [7:0] T_GA     = 8'd249;
  localparam logic [7:0] T_SE     = 8'd240;
  localparam logic [7:0] T_EORCMD = 8'd239;

  // option codes
  localparam logic [7:0] O_TTYPE    = 8'd24;
  localparam logic [7:0] O_EOR      = 8'd25;
  localparam logic [7:0] O_NAWS     = 8'd31;
  localparam logic [7:0] O_LINEMODE = 8'd34;
  localparam logic [7:0] O_CHARSET  = 8'd42;
  localparam logic [7:0] O_MSSP     = 8'd70;

  localparam logic [7:0] CS_REQUEST  = 8'd1;
  localparam logic [7:0] CS_ACCEPTED = 8'd2;
  localparam logic [7:0] TT_IS       = 8'd0;

  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_LF = 8'd10;

  // default name length limit and job queue depth
  localparam int CHARSET_NAME_MAX_DEF = 20;
  localparam int JOB_Q_DEPTH          = 4;

  // charset request list length
  localparam int CS_ROM_LEN = 43;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NAWS_WIDTH  = 2'd0,
    CFG_NAWS_HEIGHT = 2'd1,
    CFG_TERM_NAME   = 2'd2,
    CFG_TERM_LEN    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] naws_width;
    logic [15:0] naws_height;
    logic [47:0] term_name;
    logic [2:0]  term_name_len;
  } cfg_t;

  // result kinds
  typedef enum logic [2:0] {
    KIND_TEXT   = 3'd0,
    KIND_EOL    = 3'd1,
    KIND_PROMPT = 3'd2,
    KIND_REPLY  = 3'd3,
    KIND_CSBYTE = 3'd4,
    KIND_CSEND  = 3'd5
  } kind_e;

  // parser phases
  typedef enum logic [3:0] {
    PH_NORMAL, PH_IAC, PH_DO, PH_WILL, PH_SKIP1, PH_SB,
    PH_TT1, PH_TT2, PH_TT3, PH_MSSP, PH_MSSP_IAC,
    PH_CS_SUB, PH_CS_SKIP1, PH_CS_SKIP2, PH_CS_NAME, PH_CS_SE
  } phase_e;

  // back-end actions
  typedef enum logic [3:0] {
    ACT_NONE,      // only the opening will-charset reply
    ACT_TEXT,
    ACT_EOL,
    ACT_PROMPT,
    ACT_CSBYTE,
    ACT_CSEND,
    ACT_R3,        // iac, cmd, option
    ACT_NAWS,      // iac, cmd, naws, then window size subnegotiation
    ACT_CHARSETS,  // charset request list
    ACT_TTYPE      // terminal type is <name>
  } act_e;

  typedef struct packed {
    logic       first;  // prefix with iac will charset
    act_e       act;
    logic [7:0] cmd;
    logic [7:0] data;
  } job_t;

  // charset request list ";UTF-8;ISO-8859-1;ISO-8859-2;US-ASCII;CP437"
  function automatic logic [7:0] cs_rom(input logic [5:0] i);
    logic [7:0] r;
    case (i)
      6'd0:  r = 8'h3B; 6'd1:  r = 8'h55; 6'd2:  r = 8'h54; 6'd3:  r = 8'h46;
      6'd4:  r = 8'h2D; 6'd5:  r = 8'h38; 6'd6:  r = 8'h3B; 6'd7:  r = 8'h49;
      6'd8:  r = 8'h53; 6'd9:  r = 8'h4F; 6'd10: r = 8'h2D; 6'd11: r = 8'h38;
      6'd12: r = 8'h38; 6'd13: r = 8'h35; 6'd14: r = 8'h39; 6'd15: r = 8'h2D;
      6'd16: r = 8'h31; 6'd17: r = 8'h3B; 6'd18: r = 8'h49; 6'd19: r = 8'h53;
      6'd20: r = 8'h4F; 6'd21: r = 8'h2D; 6'd22: r = 8'h38; 6'd23: r = 8'h38;
      6'd24: r = 8'h35; 6'd25: r = 8'h39; 6'd26: r = 8'h2D; 6'd27: r = 8'h32;
      6'd28: r = 8'h3B; 6'd29: r = 8'h55; 6'd30: r = 8'h53; 6'd31: r = 8'h2D;
      6'd32: r = 8'h41; 6'd33: r = 8'h53; 6'd34: r = 8'h43; 6'd35: r = 8'h49;
      6'd36: r = 8'h49; 6'd37: r = 8'h3B; 6'd38: r = 8'h43; 6'd39: r = 8'h50;
      6'd40: r = 8'h34; 6'd41: r = 8'h33; 6'd42: r = 8'h37;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tnrn_rx_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_rx_if: received byte channel
// Valid/ready channel carrying one received telnet byte per transfer.
// ----------------------------------------------------------------------------
interface tnrn_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ rtl/tnrn_res_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_res_if: result channel
// Valid/ready channel carrying one result item per transfer.
// ----------------------------------------------------------------------------
interface tnrn_res_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output data_byte, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

@@ rtl/tnrn_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_front: byte parser
// Accepts received bytes, tracks the telnet parse phase and turns each byte
// that causes output into one job for the back end.
// ----------------------------------------------------------------------------
module tnrn_front #(
  parameter int CHARSET_NAME_MAX = tnrn_pkg::CHARSET_NAME_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tnrn_rx_if.sink       rx_i,
  input  logic          full_i,
  output logic          push_o,
  output tnrn_pkg::job_t job_o
);
  import tnrn_pkg::*;

  localparam int CNT_W = $clog2(CHARSET_NAME_MAX + 1);

  phase_e           phase_q, phase_d;
  logic             started_q, started_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             has_job;
  job_t             job;
  logic             take;
  logic [7:0]       b;

  assign rx_i.ready = !full_i;
  assign take       = rx_i.valid && !full_i;
  assign b          = rx_i.rx_byte;

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_NORMAL:   if (b == T_IAC) phase_d = PH_IAC;
      PH_IAC: begin
        case (b)
          T_DO:           phase_d = PH_DO;
          T_WILL:         phase_d = PH_WILL;
          T_SB:           phase_d = PH_SB;
          T_DONT, T_WONT: phase_d = PH_SKIP1;
          default:        phase_d = PH_NORMAL;
        endcase
      end
      PH_SB: begin
        case (b)
          O_TTYPE:   phase_d = PH_TT1;
          O_MSSP:    phase_d = PH_MSSP;
          O_CHARSET: phase_d = PH_CS_SUB;
          default:   phase_d = PH_NORMAL;
        endcase
      end
      PH_TT1:      phase_d = PH_TT2;
      PH_TT2:      phase_d = PH_TT3;
      PH_MSSP:     if (b == T_IAC) phase_d = PH_MSSP_IAC;
      PH_MSSP_IAC: phase_d = (b == T_IAC) ? PH_MSSP : PH_NORMAL;
      PH_CS_SUB:   phase_d = (b == CS_ACCEPTED) ? PH_CS_NAME : PH_CS_SKIP1;
      PH_CS_SKIP1: phase_d = PH_CS_SKIP2;
      PH_CS_NAME:  if (b == T_IAC) phase_d = PH_CS_SE;
      PH_DO, PH_WILL, PH_SKIP1, PH_TT3, PH_CS_SKIP2, PH_CS_SE:
                   phase_d = PH_NORMAL;
      default:     phase_d = PH_NORMAL;
    endcase
  end

  // job and counters
  always_comb begin
    has_job    = 1'b0;
    job.first  = 1'b0;
    job.act    = ACT_NONE;
    job.cmd    = 8'd0;
    job.data   = b;
    started_d  = started_q;
    cnt_d      = cnt_q;
    unique case (phase_q)
      PH_NORMAL: begin
        if (b == CH_LF) begin
          has_job = 1'b1;
          job.act = ACT_EOL;
        end else if (b != CH_CR && b != T_IAC) begin
          has_job = 1'b1;
          job.act = ACT_TEXT;
        end
      end
      PH_IAC: begin
        if (b == T_IAC) begin
          has_job = 1'b1;
          job.act = ACT_TEXT;
        end else begin
          job.first = !started_q;
          started_d = 1'b1;
          if (b == T_GA || b == T_EORCMD) begin
            job.act = ACT_PROMPT;
            has_job = 1'b1;
          end else begin
            has_job = !started_q;
          end
        end
      end
      PH_DO: begin
        has_job = 1'b1;
        case (b)
          O_LINEMODE: begin job.act = ACT_R3;       job.cmd = T_WONT; end
          O_TTYPE:    begin job.act = ACT_R3;       job.cmd = T_WILL; end
          O_NAWS:     begin job.act = ACT_NAWS;     job.cmd = T_WILL; end
          O_CHARSET:  begin job.act = ACT_CHARSETS; end
          default:    has_job = 1'b0;
        endcase
      end
      PH_WILL: begin
        has_job = 1'b1;
        job.cmd = T_DO;
        case (b)
          O_EOR, O_MSSP, O_CHARSET: job.act = ACT_R3;
          O_NAWS:                   job.act = ACT_NAWS;
          default:                  has_job = 1'b0;
        endcase
      end
      PH_TT3: begin
        has_job = 1'b1;
        job.act = ACT_TTYPE;
      end
      PH_CS_SUB: begin
        if (b == CS_ACCEPTED) cnt_d = '0;
      end
      PH_CS_NAME: begin
        if (b != T_IAC && cnt_q < CNT_W'(CHARSET_NAME_MAX)) begin
          has_job = 1'b1;
          job.act = ACT_CSBYTE;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      PH_CS_SE: begin
        has_job = 1'b1;
        job.act = ACT_CSEND;
      end
      PH_SKIP1, PH_SB, PH_TT1, PH_TT2, PH_MSSP, PH_MSSP_IAC, PH_CS_SKIP1, PH_CS_SKIP2: ;
      default: ;
    endcase
  end

  assign push_o = take && has_job;
  assign job_o  = job;

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_NORMAL;
      started_q <= 1'b0;
      cnt_q     <= '0;
    end else if (take) begin
      phase_q   <= phase_d;
      started_q <= started_d;
      cnt_q     <= cnt_d;
    end
  end

endmodule

@@ rtl/tnrn_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_fifo: job queue
// Short queue of parsed jobs between the parser and the reply sequencer.
// ----------------------------------------------------------------------------
module tnrn_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tnrn_pkg::job_t push_job_i,
  input  logic           pop_i,
  output tnrn_pkg::job_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import tnrn_pkg::*;

  localparam int PTR_W = $clog2(JOB_Q_DEPTH);

  job_t             mem_q [JOB_Q_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(JOB_Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_job_i;
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= (wptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (pop_i)  rptr_q <= (rptr_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("job popped from empty queue");
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue level out of step");

endmodule

@@ rtl/tnrn_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_back: reply sequencer
// Expands the job at the head of the queue into result items, one per
// cycle unless res_o holds the output register, doubling iac data bytes in
// replies, into an output register.
module tnrn_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tnrn_pkg::cfg_t cfg_i,
  input  tnrn_pkg::job_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  tnrn_res_if.source     res_o
);
  import tnrn_pkg::*;

  logic [5:0] idx_q, idx_d;
  logic       pre_done_q, pre_done_d;
  logic       dup_q, dup_d;
  logic       out_valid_q;
  kind_e      kind_q;
  logic [7:0] data_q;
  logic       last_q;

  kind_e      b_kind, g_kind;
  logic [7:0] b_byte, g_byte;
  logic       b_esc;
  logic [5:0] b_len;
  logic [5:0] off;
  logic [2:0] nlen;
  logic       in_pre, need_dup, g_last, fire;

  assign off  = idx_q - 6'd4;
  assign nlen = (cfg_i.term_name_len > 3'd6) ? 3'd6 : cfg_i.term_name_len;

  // body item of the current job at idx_q
  always_comb begin
    b_kind = KIND_REPLY;
    b_byte = 8'd0;
    b_esc  = 1'b0;
    b_len  = 6'd1;
    unique case (head_i.act)
      ACT_NONE:   b_len = 6'd0;
      ACT_TEXT:   begin b_kind = KIND_TEXT;   b_byte = head_i.data; end
      ACT_EOL:    b_kind = KIND_EOL;
      ACT_PROMPT: b_kind = KIND_PROMPT;
      ACT_CSBYTE: begin b_kind = KIND_CSBYTE; b_byte = head_i.data; end
      ACT_CSEND:  b_kind = KIND_CSEND;
      ACT_R3: begin
        b_len = 6'd3;
        case (idx_q)
          6'd0:    b_byte = T_IAC;
          6'd1:    b_byte = head_i.cmd;
          default: b_byte = head_i.data;
        endcase
      end
      ACT_NAWS: begin
        b_len = 6'd12;
        b_esc = (idx_q >= 6'd6) && (idx_q <= 6'd9);
        case (idx_q)
          6'd0:    b_byte = T_IAC;
          6'd1:    b_byte = head_i.cmd;
          6'd2:    b_byte = O_NAWS;
          6'd3:    b_byte = T_IAC;
          6'd4:    b_byte = T_SB;
          6'd5:    b_byte = O_NAWS;
          6'd6:    b_byte = cfg_i.naws_width[15:8];
          6'd7:    b_byte = cfg_i.naws_width[7:0];
          6'd8:    b_byte = cfg_i.naws_height[15:8];
          6'd9:    b_byte = cfg_i.naws_height[7:0];
          6'd10:   b_byte = T_IAC;
          default: b_byte = T_SE;
        endcase
      end
      ACT_CHARSETS: begin
        b_len = 6'(CS_ROM_LEN + 6);
        if (idx_q == 6'd0)      b_byte = T_IAC;
        else if (idx_q == 6'd1) b_byte = T_SB;
        else if (idx_q == 6'd2) b_byte = O_CHARSET;
        else if (idx_q == 6'd3) b_byte = CS_REQUEST;
        else if (idx_q < 6'(CS_ROM_LEN + 4)) begin
          b_byte = cs_rom(off);
          b_esc  = 1'b1;
        end else if (idx_q == 6'(CS_ROM_LEN + 4)) b_byte = T_IAC;
        else b_byte = T_SE;
      end
      ACT_TTYPE: begin
        b_len = 6'd6 + 6'(nlen);
        if (idx_q == 6'd0)      b_byte = T_IAC;
        else if (idx_q == 6'd1) b_byte = T_SB;
        else if (idx_q == 6'd2) b_byte = O_TTYPE;
        else if (idx_q == 6'd3) b_byte = TT_IS;
        else if (idx_q < 6'd4 + 6'(nlen)) begin
          b_esc = 1'b1;
          case (off[2:0])
            3'd0:    b_byte = cfg_i.term_name[47:40];
            3'd1:    b_byte = cfg_i.term_name[39:32];
            3'd2:    b_byte = cfg_i.term_name[31:24];
            3'd3:    b_byte = cfg_i.term_name[23:16];
            3'd4:    b_byte = cfg_i.term_name[15:8];
            default: b_byte = cfg_i.term_name[7:0];
          endcase
        end else if (idx_q == 6'd4 + 6'(nlen)) b_byte = T_IAC;
        else b_byte = T_SE;
      end
      default: b_len = 6'd0;
    endcase
  end

  // step through the will-charset prefix, then the body
  always_comb begin
    in_pre     = head_i.first && !pre_done_q;
    fire       = !empty_i && (!out_valid_q || res_o.ready);
    need_dup   = 1'b0;
    idx_d      = idx_q;
    pre_done_d = pre_done_q;
    dup_d      = dup_q;
    if (in_pre) begin
      g_kind = KIND_REPLY;
      case (idx_q)
        6'd0:    g_byte = T_IAC;
        6'd1:    g_byte = T_WILL;
        default: g_byte = O_CHARSET;
      endcase
      g_last = (idx_q == 6'd2) && (b_len == 6'd0);
      if (idx_q == 6'd2) begin
        pre_done_d = 1'b1;
        idx_d      = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end else begin
      g_kind   = b_kind;
      g_byte   = b_byte;
      need_dup = b_esc && (b_byte == T_IAC) && !dup_q;
      g_last   = !need_dup && (idx_q == b_len - 6'd1);
      dup_d    = need_dup;
      if (!need_dup) idx_d = idx_q + 1'b1;
    end
    if (g_last) begin
      idx_d      = '0;
      pre_done_d = 1'b0;
      dup_d      = 1'b0;
    end
  end

  assign pop_o = fire && g_last;

  // sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      pre_done_q <= 1'b0;
      dup_q      <= 1'b0;
    end else if (fire) begin
      idx_q      <= idx_d;
      pre_done_q <= pre_done_d;
      dup_q      <= dup_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      kind_q <= g_kind;
      data_q <= g_byte;
      last_q <= g_last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.kind      = kind_q;
  assign res_o.data_byte = data_q;
  assign res_o.last      = last_q;

  a_pre_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (head_i.first && !pre_done_q && !empty_i) |-> idx_q <= 6'd2)
    else $error("prefix index out of range");
  a_dup_body: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_q |-> (pre_done_q || !head_i.first))
    else $error("escape pending inside prefix");
  a_pop_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (idx_q == '0 && !dup_q && !pre_done_q))
    else $error("sequencer not cleared after job end");

endmodule

@@ rtl/telnet_receive_negotiator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_receive_negotiator: telnet receive parser and option negotiator
// Parses received telnet bytes and emits text, line and prompt marks,
// negotiation replies for the network and accepted charset names.
// ----------------------------------------------------------------------------
// usage
//   rx_i carries one received byte per transfer; res_o carries result items
//   (kind, data_byte, last), last set on the final item caused by a byte.
//   cfg_we_i / cfg_idx_i / cfg_data_i write naws_width, naws_height,
//   term_name and term_name_len; write only while the block is idle.
// timing
//   the parser takes one byte per cycle while the job queue is not full and
//   queues one job per byte that causes output; the sequencer emits one
//   result item per cycle, while res_o is not held, into an output register,
//   so the first item of a byte passes through the job queue and then the
//   output register. a reply burst has up to 49 items for the charset list,
//   all sent through the single output port of the sequencer.
// reset
//   parser returns to plain data, negotiation not started, job queue and
//   output register empty; registers return to 92 / 19 / empty name.
// stalls
//   when res_o is held, the output register keeps its item and the job
//   queue fills; rx_i.ready drops only once the queue is full.
// ----------------------------------------------------------------------------
module telnet_receive_negotiator #(
  parameter int CHARSET_NAME_MAX = tnrn_pkg::CHARSET_NAME_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tnrn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tnrn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tnrn_rx_if.sink                        rx_i,
  tnrn_res_if.source                     res_o
);
  import tnrn_pkg::*;

  cfg_t cfg_q;
  job_t push_job, head;
  logic push, pop, full, empty;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.naws_width    <= 16'd92;
      cfg_q.naws_height   <= 16'd19;
      cfg_q.term_name     <= '0;
      cfg_q.term_name_len <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_NAWS_WIDTH:  cfg_q.naws_width    <= cfg_data_i[15:0];
        CFG_NAWS_HEIGHT: cfg_q.naws_height   <= cfg_data_i[15:0];
        CFG_TERM_NAME:   cfg_q.term_name     <= cfg_data_i[47:0];
        CFG_TERM_LEN:    cfg_q.term_name_len <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // parser
  tnrn_front #(
    .CHARSET_NAME_MAX(CHARSET_NAME_MAX)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_i),
    .full_i(full),
    .push_o(push),
    .job_o (push_job)
  );

  // job queue
  tnrn_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_job_i(push_job),
    .pop_i     (pop),
    .head_o    (head),
    .full_o    (full),
    .empty_o   (empty)
  );

  // reply sequencer
  tnrn_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .head_i (head),
    .empty_i(empty),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule

@@ tb/tnrn_negotiation_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tnrn_negotiation_checker: result checker of the telnet receive negotiator
// Watches the byte and result channels and the register write port, keeps its
// own parser state and register copy, works out the result items that each
// received byte causes and compares them in order with the block's results.
// ----------------------------------------------------------------------------
module tnrn_negotiation_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tnrn_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tnrn_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tnrn_rx_if                              rx_i,
  tnrn_res_if                             res_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  import tnrn_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       last;
  } res_item_t;

  // charset request list, first character in the top byte
  localparam logic [8*CS_ROM_LEN-1:0] CS_LIST = ";UTF-8;ISO-8859-1;ISO-8859-2;US-ASCII;CP437";

  res_item_t   parsed_items[$];
  phase_e      rx_phase;
  logic        neg_started;
  int unsigned cs_name_cnt;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic [47:0] ttype_name;
  logic [2:0]  ttype_len;
  res_item_t   want;

  function automatic void add_item(kind_e k, logic [7:0] d);
    parsed_items.push_back('{kind: k, data: d, last: 1'b0});
  endfunction

  function automatic void add_reply(logic [7:0] b);
    add_item(KIND_REPLY, b);
  endfunction

  // data bytes inside a reply have iac doubled
  function automatic void add_reply_esc(logic [7:0] b);
    add_reply(b);
    if (b == T_IAC) add_reply(b);
  endfunction

  function automatic void add_reply3(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    add_reply(a);
    add_reply(b);
    add_reply(c);
  endfunction

  function automatic void add_window_size();
    add_reply3(T_IAC, T_SB, O_NAWS);
    add_reply_esc(win_width[15:8]);
    add_reply_esc(win_width[7:0]);
    add_reply_esc(win_height[15:8]);
    add_reply_esc(win_height[7:0]);
    add_reply(T_IAC);
    add_reply(T_SE);
  endfunction

  function automatic void add_charset_request();
    add_reply3(T_IAC, T_SB, O_CHARSET);
    add_reply(CS_REQUEST);
    for (int i = 0; i < CS_ROM_LEN; i++)
      add_reply_esc(CS_LIST[8*(CS_ROM_LEN-1-i) +: 8]);
    add_reply(T_IAC);
    add_reply(T_SE);
  endfunction

  // name length above six counts as six
  function automatic void add_ttype_is();
    int n;
    n = (ttype_len > 3'd6) ? 6 : int'(ttype_len);
    add_reply3(T_IAC, T_SB, O_TTYPE);
    add_reply(TT_IS);
    for (int i = 0; i < n; i++)
      add_reply_esc(ttype_name[47-8*i -: 8]);
    add_reply(T_IAC);
    add_reply(T_SE);
  endfunction

  // command byte after iac; the first one opens with will charset
  function automatic void take_command(logic [7:0] b);
    if (!neg_started) begin
      neg_started = 1'b1;
      add_reply3(T_IAC, T_WILL, O_CHARSET);
    end
    case (b)
      T_DO:            rx_phase = PH_DO;
      T_WILL:          rx_phase = PH_WILL;
      T_SB:            rx_phase = PH_SB;
      T_DONT, T_WONT:  rx_phase = PH_SKIP1;
      T_GA, T_EORCMD: begin
        add_item(KIND_PROMPT, 8'h00);
        rx_phase = PH_NORMAL;
      end
      default:         rx_phase = PH_NORMAL;
    endcase
  endfunction

  // advance the parser by one received byte and queue what it causes
  function automatic void parse_rx_byte(logic [7:0] b);
    int        start_size;
    res_item_t tail;
    start_size = parsed_items.size();
    case (rx_phase)
      PH_NORMAL: begin
        if (b == CH_CR) begin
        end else if (b == CH_LF) begin
          add_item(KIND_EOL, 8'h00);
        end else if (b == T_IAC) begin
          rx_phase = PH_IAC;
        end else begin
          add_item(KIND_TEXT, b);
        end
      end
      PH_IAC: begin
        if (b == T_IAC) begin
          add_item(KIND_TEXT, T_IAC);
          rx_phase = PH_NORMAL;
        end else begin
          take_command(b);
        end
      end
      PH_DO: begin
        rx_phase = PH_NORMAL;
        case (b)
          O_LINEMODE: add_reply3(T_IAC, T_WONT, O_LINEMODE);
          O_TTYPE:    add_reply3(T_IAC, T_WILL, O_TTYPE);
          O_NAWS: begin
            add_reply3(T_IAC, T_WILL, O_NAWS);
            add_window_size();
          end
          O_CHARSET:  add_charset_request();
          default: ;
        endcase
      end
      PH_WILL: begin
        rx_phase = PH_NORMAL;
        case (b)
          O_EOR:     add_reply3(T_IAC, T_DO, O_EOR);
          O_MSSP:    add_reply3(T_IAC, T_DO, O_MSSP);
          O_NAWS: begin
            add_reply3(T_IAC, T_DO, O_NAWS);
            add_window_size();
          end
          O_CHARSET: add_reply3(T_IAC, T_DO, O_CHARSET);
          default: ;
        endcase
      end
      PH_SKIP1: rx_phase = PH_NORMAL;
      PH_SB: begin
        case (b)
          O_TTYPE:   rx_phase = PH_TT1;
          O_MSSP:    rx_phase = PH_MSSP;
          O_CHARSET: rx_phase = PH_CS_SUB;
          default:   rx_phase = PH_NORMAL;
        endcase
      end
      PH_TT1: rx_phase = PH_TT2;
      PH_TT2: rx_phase = PH_TT3;
      PH_TT3: begin
        rx_phase = PH_NORMAL;
        add_ttype_is();
      end
      PH_MSSP: begin
        if (b == T_IAC) rx_phase = PH_MSSP_IAC;
      end
      PH_MSSP_IAC: rx_phase = (b == T_IAC) ? PH_MSSP : PH_NORMAL;
      PH_CS_SUB: begin
        if (b == CS_ACCEPTED) begin
          cs_name_cnt = 0;
          rx_phase = PH_CS_NAME;
        end else begin
          rx_phase = PH_CS_SKIP1;
        end
      end
      PH_CS_SKIP1: rx_phase = PH_CS_SKIP2;
      PH_CS_SKIP2: rx_phase = PH_NORMAL;
      PH_CS_NAME: begin
        if (b == T_IAC) begin
          rx_phase = PH_CS_SE;
        end else if (cs_name_cnt < CHARSET_NAME_MAX_DEF) begin
          add_item(KIND_CSBYTE, b);
          cs_name_cnt++;
        end
      end
      default: begin
        add_item(KIND_CSEND, 8'h00);
        rx_phase = PH_NORMAL;
      end
    endcase
    // mark the final item of this byte
    if (parsed_items.size() > start_size) begin
      tail = parsed_items.pop_back();
      tail.last = 1'b1;
      parsed_items.push_back(tail);
    end
  endfunction

  task automatic flag_error(input string what, input res_item_t exp_item);
    fail_count_o = fail_count_o + 1;
    if (fail_count_o <= 10)
      $display("%0t %s: expected kind %0d data %02h last %0b, got kind %0d data %02h last %0b",
               $time, what, exp_item.kind, exp_item.data, exp_item.last,
               res_i.kind, res_i.data_byte, res_i.last);
  endtask

  // register copy, parser and in-order compare
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parsed_items.delete();
      rx_phase     = PH_NORMAL;
      neg_started  = 1'b0;
      cs_name_cnt  = 0;
      win_width    = 16'd92;
      win_height   = 16'd19;
      ttype_name   = '0;
      ttype_len    = '0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_NAWS_WIDTH:  win_width  = cfg_data_i[15:0];
          CFG_NAWS_HEIGHT: win_height = cfg_data_i[15:0];
          CFG_TERM_NAME:   ttype_name = cfg_data_i[47:0];
          CFG_TERM_LEN:    ttype_len  = cfg_data_i[2:0];
          default: ;
        endcase
      end
      if (rx_i.valid && rx_i.ready)
        parse_rx_byte(rx_i.rx_byte);
      if (res_i.valid && res_i.ready) begin
        if (parsed_items.size() == 0) begin
          flag_error("result with nothing pending", '0);
        end else begin
          want = parsed_items.pop_front();
          if (res_i.kind !== want.kind || res_i.data_byte !== want.data ||
              res_i.last !== want.last)
            flag_error("result mismatch", want);
        end
      end
      pending_o = parsed_items.size();
    end
  end

endmodule

@@ tb/tb_telnet_receive_negotiator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telnet_receive_negotiator: testbench of the telnet receive negotiator
// Sends a short directed byte stream and then random telnet sequences under
// several register settings and idle patterns, with one long result hold-off;
// the checker beside the block compares every result and the top gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_telnet_receive_negotiator;
  import tnrn_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_OFF    = 300;
  localparam int SETTLE      = 4;
  localparam int SEQ_PER_RUN = 40;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    src_idle_pct;
  int                    sink_idle_pct;
  logic                  hold_req;
  int                    hold_left;

  tnrn_rx_if  rx ();
  tnrn_res_if res ();

  telnet_receive_negotiator dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .rx_i      (rx),
    .res_o     (res)
  );

  tnrn_negotiation_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .rx_i        (rx),
    .res_i       (res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side: random stalls, or a counted hold-off once requested
  initial begin
    res.ready = 1'b0;
    hold_left = HOLD_OFF;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left > 0) begin
        hold_left = hold_left - 1;
        res.ready <= 1'b0;
      end else begin
        res.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((rx.valid && rx.ready) || (res.valid && res.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_telnet_receive_negotiator: FAIL");
    $finish;
  end

  // one byte transfer, with random idle cycles ahead of it
  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      rx.valid <= 1'b0;
      @(negedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk); while (!rx.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we   <= 1'b0;
    @(negedge clk);
  endtask

  // sender pause until every result is out, plus the pipeline tail
  task automatic drain();
    rx.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // mostly known options, sometimes any byte
  function automatic logic [7:0] pick_option();
    logic [7:0] opts[6];
    opts = '{O_TTYPE, O_EOR, O_NAWS, O_LINEMODE, O_CHARSET, O_MSSP};
    if ($urandom_range(9) < 8) return opts[$urandom_range(5)];
    return 8'($urandom_range(255));
  endfunction

  // one random telnet sequence, well formed most of the time
  task automatic put_random_sequence();
    logic [7:0] seq[$];
    logic [7:0] b;
    int         pick;
    int         n;
    pick = $urandom_range(99);
    if (pick < 28) begin
      seq.push_back(8'($urandom_range(254)));
    end else if (pick < 32) begin
      seq.push_back(CH_CR);
      seq.push_back(CH_LF);
    end else if (pick < 36) begin
      seq = '{T_IAC, T_IAC};
    end else if (pick < 42) begin
      seq = '{T_IAC, ($urandom_range(1) ? T_GA : T_EORCMD)};
    end else if (pick < 52) begin
      seq = '{T_IAC, T_DO, pick_option()};
    end else if (pick < 62) begin
      seq = '{T_IAC, T_WILL, pick_option()};
    end else if (pick < 66) begin
      seq = '{T_IAC, ($urandom_range(1) ? T_DONT : T_WONT), 8'($urandom_range(255))};
    end else if (pick < 70) begin
      // mostly unknown command codes, se and eor among them
      seq = '{T_IAC, 8'($urandom_range(248))};
    end else if (pick < 75) begin
      // terminal type send, or three arbitrary bytes
      if ($urandom_range(3) != 0) seq = '{T_IAC, T_SB, O_TTYPE, 8'h01, T_IAC, T_SE};
      else seq = '{T_IAC, T_SB, O_TTYPE, 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (pick < 80) begin
      // mssp body with doubled iac, closed by iac and a non-iac byte
      seq = '{T_IAC, T_SB, O_MSSP};
      n = $urandom_range(6);
      repeat (n) begin
        b = 8'($urandom_range(255));
        seq.push_back(b);
        if (b == T_IAC) seq.push_back(b);
      end
      seq.push_back(T_IAC);
      seq.push_back($urandom_range(3) != 0 ? T_SE : 8'($urandom_range(254)));
    end else if (pick < 88) begin
      // accepted charset name, sometimes longer than the limit
      seq = '{T_IAC, T_SB, O_CHARSET, CS_ACCEPTED};
      n = ($urandom_range(4) == 0) ? $urandom_range(21, 30) : $urandom_range(12);
      repeat (n) seq.push_back(8'($urandom_range(254)));
      seq.push_back(T_IAC);
      seq.push_back($urandom_range(3) != 0 ? T_SE : 8'($urandom_range(255)));
    end else if (pick < 91) begin
      b = 8'($urandom_range(255));
      if (b == CS_ACCEPTED) b = CS_REQUEST;
      seq = '{T_IAC, T_SB, O_CHARSET, b, 8'($urandom_range(255)), 8'($urandom_range(255))};
    end else if (pick < 93) begin
      b = 8'($urandom_range(255));
      if (b == O_TTYPE || b == O_MSSP || b == O_CHARSET) b = 8'h00;
      seq = '{T_IAC, T_SB, b};
    end else begin
      // noise: any bytes, may leave a sequence half done
      n = $urandom_range(1, 3);
      repeat (n) seq.push_back(8'($urandom_range(255)));
    end
    foreach (seq[i]) put_byte(seq[i]);
  endtask

  task automatic run_sequences(input int count);
    repeat (count) begin
      if ($urandom_range(24) == 0) drain();
      put_random_sequence();
    end
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0] opening[$];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = '0;
    cfg_data      = '0;
    rx.valid      = 1'b0;
    rx.rx_byte    = '0;
    hold_req      = 1'b0;
    src_idle_pct  = 18;
    sink_idle_pct = 58;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed opening with register values after reset
    opening = '{8'h00, 8'hFE, CH_CR, CH_LF, T_IAC, T_IAC,
                T_IAC, T_DO, O_NAWS, T_IAC, T_GA, T_IAC, T_EORCMD,
                T_IAC, T_DO, O_CHARSET, T_IAC, 8'h00,
                T_IAC, T_SB, O_TTYPE, 8'h01, T_IAC, T_SE};
    foreach (opening[i]) put_byte(opening[i]);

    // extremes, escaped size bytes, name length over six
    drain();
    write_reg(CFG_NAWS_WIDTH, 48'hFFFF);
    write_reg(CFG_NAWS_HEIGHT, 48'h0000);
    write_reg(CFG_TERM_NAME, 48'hFFFF_FFFF_FFFF);
    write_reg(CFG_TERM_LEN, 48'd7);
    run_sequences(SEQ_PER_RUN);

    drain();
    src_idle_pct  = 58;
    sink_idle_pct = 18;
    write_reg(CFG_NAWS_WIDTH, 48'h0000);
    write_reg(CFG_NAWS_HEIGHT, 48'hFFFF);
    write_reg(CFG_TERM_NAME, 48'({$urandom, $urandom}));
    write_reg(CFG_TERM_LEN, 48'd0);
    run_sequences(SEQ_PER_RUN);

    drain();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_reg(CFG_NAWS_WIDTH, 48'($urandom_range(65535)));
    write_reg(CFG_NAWS_HEIGHT, 48'($urandom_range(65535)));
    write_reg(CFG_TERM_NAME, 48'({$urandom, $urandom}));
    write_reg(CFG_TERM_LEN, 48'($urandom_range(1, 6)));
    run_sequences(SEQ_PER_RUN / 2);

    // long result hold-off while text and a charset request keep coming
    hold_req = 1'b1;
    repeat (20) put_byte(8'($urandom_range(32, 126)));
    put_byte(T_IAC);
    put_byte(T_DO);
    put_byte(O_CHARSET);
    run_sequences(SEQ_PER_RUN / 2);

    // wind down and give the verdict
    drain();
    repeat (16) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_telnet_receive_negotiator: PASS");
    end else begin
      $display("tb_telnet_receive_negotiator: FAIL");
    end
    $finish;
  end

endmodule
